// ===== design/substring_occurrence_finder_core_assert.svh =====
// -----------------------------------------------------------------------------
// Substring finder assertion macros
// Property shapes for the checker of the substring finder core.
// -----------------------------------------------------------------------------
`ifndef SUBSTRING_OCCURRENCE_FINDER_CORE_ASSERT_SVH
`define SUBSTRING_OCCURRENCE_FINDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SOFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sofc_pkg.sv =====
// -----------------------------------------------------------------------------
// Substring finder package
// Sizes, register and mode codes, shared structs and the ASCII fold function.
// -----------------------------------------------------------------------------
package sofc_pkg;

	localparam int NEEDLE_MAX   = 16;
	localparam int MAX_LENGTH   = 65535;
	localparam int OCC_MAX      = 16;

	localparam int BYTE_W       = 8;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int NEEDLE_BYTES = 2 * CFG_W / BYTE_W;
	localparam int NB_AW        = $clog2(NEEDLE_BYTES);
	localparam int LEN_W        = 5;
	localparam int OCC_W        = 5;
	localparam int POS_W        = 16;
	localparam int CNT_W        = $clog2(MAX_LENGTH + 2);
	localparam int RING_AW      = (OCC_MAX > 1) ? $clog2(OCC_MAX) : 1;

	localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [BYTE_W-1:0] ASCII_CASE_OFS = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEEDLE_LO   = 3'd0,
		REG_NEEDLE_HI   = 3'd1,
		REG_NEEDLE_LEN  = 3'd2,
		REG_CASE_SENS   = 3'd3,
		REG_SEARCH_MODE = 3'd4,
		REG_OCCURRENCE  = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_FORWARD  = 2'd0,
		MODE_BACKWARD = 2'd1,
		MODE_COUNT    = 2'd2
	} mode_t;

	// Config as seen by the datapath: needle already aligned to the window
	// (entry j pairs with window byte j) and folded when case-insensitive.
	typedef struct packed {
		logic [NEEDLE_MAX-1:0][BYTE_W-1:0] needle_al;
		logic [NEEDLE_MAX-1:0]             cmp_mask;
		logic                              len_ok;
		logic                              fold_en;
		logic [LEN_W-1:0]                  len;
		mode_t                             mode;
		logic [OCC_W-1:0]                  occ;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] match_position;
		logic [POS_W-1:0] match_count;
		logic             too_long;
	} res_t;

	function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
			r = c + ASCII_CASE_OFS;
		end
		return r;
	endfunction

endpackage

// ===== design/sofc_in_if.sv =====
// -----------------------------------------------------------------------------
// Haystack channel
// Valid/ready channel that carries one haystack byte and its last-byte mark.
// -----------------------------------------------------------------------------
interface sofc_in_if import sofc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] hay_byte;
	logic              last_byte;

	modport source (output valid, output hay_byte, output last_byte, input ready);
	modport sink   (input valid, input hay_byte, input last_byte, output ready);
endinterface

// ===== design/sofc_out_if.sv =====
// -----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one search result.
// -----------------------------------------------------------------------------
interface sofc_out_if import sofc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] match_position;
	logic [POS_W-1:0] match_count;
	logic             too_long;

	modport source (output valid, output match_position, output match_count,
		output too_long, input ready);
	modport sink   (input valid, input match_position, input match_count,
		input too_long, output ready);
endinterface

// ===== design/sofc_cfg_regs.sv =====
// -----------------------------------------------------------------------------
// Substring finder configuration registers
// Write-only register file plus a registered, window-aligned needle image.
// -----------------------------------------------------------------------------
module sofc_cfg_regs import sofc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	logic [CFG_W-1:0] needle_lo_q;
	logic [CFG_W-1:0] needle_hi_q;
	logic [LEN_W-1:0] len_q;
	logic             case_q;
	mode_t            mode_q;
	logic [OCC_W-1:0] occ_q;
	cfg_t             cfg_q;
	cfg_t             cfg_d;

	logic [NEEDLE_BYTES-1:0][BYTE_W-1:0] needle_bytes;

	assign needle_bytes = {needle_hi_q, needle_lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_lo_q <= '0;
			needle_hi_q <= '0;
			len_q       <= '0;
			case_q      <= 1'b1;
			mode_q      <= MODE_FORWARD;
			occ_q       <= OCC_W'(1);
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_NEEDLE_LO:   needle_lo_q <= wr_data;
				REG_NEEDLE_HI:   needle_hi_q <= wr_data;
				REG_NEEDLE_LEN:  len_q       <= wr_data[LEN_W-1:0];
				REG_CASE_SENS:   case_q      <= wr_data[0];
				REG_SEARCH_MODE: mode_q      <= mode_t'(wr_data[1:0]);
				REG_OCCURRENCE:  occ_q       <= wr_data[OCC_W-1:0];
				default: ;
			endcase
		end
	end

	// Reverse the needle so entry j lines up with window byte j (newest byte
	// at 0), and fold it once here instead of on every compare.
	always_comb begin
		logic [LEN_W-1:0] sel;
		cfg_d         = '0;
		cfg_d.len_ok  = (len_q != '0) && (len_q <= LEN_W'(NEEDLE_MAX));
		cfg_d.fold_en = !case_q;
		cfg_d.len     = len_q;
		cfg_d.mode    = mode_q;
		cfg_d.occ     = occ_q;
		for (int j = 0; j < NEEDLE_MAX; j++) begin
			sel = len_q - LEN_W'(j) - LEN_W'(1);
			if (LEN_W'(j) < len_q) begin
				cfg_d.needle_al[j] = case_q ? needle_bytes[sel[NB_AW-1:0]]
					: fold_byte(needle_bytes[sel[NB_AW-1:0]]);
				cfg_d.cmp_mask[j]  = cfg_d.len_ok;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{needle_al: '0, cmp_mask: '0, len_ok: 1'b0, fold_en: 1'b0,
				len: '0, mode: MODE_FORWARD, occ: OCC_W'(1)};
		end else begin
			cfg_q <= cfg_d;
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/sofc_window_match.sv =====
// -----------------------------------------------------------------------------
// Substring finder window compare
// Shift register of the newest haystack bytes and the parallel needle compare.
// -----------------------------------------------------------------------------
module sofc_window_match import sofc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic [BYTE_W-1:0] hay_byte,
	input  logic              shift_en,
	input  logic              clear,
	output logic              hit
);

	logic [NEEDLE_MAX-1:0][BYTE_W-1:0] window_q;
	logic [NEEDLE_MAX-1:0][BYTE_W-1:0] window_nx;
	logic [NEEDLE_MAX-1:0]             eq;

	// Compare against the window as it stands after this byte shifts in.
	always_comb begin
		logic [BYTE_W-1:0] wb;
		window_nx[0] = hay_byte;
		for (int k = 1; k < NEEDLE_MAX; k++) begin
			window_nx[k] = window_q[k-1];
		end
		for (int j = 0; j < NEEDLE_MAX; j++) begin
			wb    = cfg.fold_en ? fold_byte(window_nx[j]) : window_nx[j];
			eq[j] = !cfg.cmp_mask[j] || (wb == cfg.needle_al[j]);
		end
		hit = cfg.len_ok && (&eq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (clear) begin
			window_q <= '0;
		end else if (shift_en) begin
			window_q <= window_nx;
		end
	end

endmodule

// ===== design/sofc_hit_track.sv =====
// -----------------------------------------------------------------------------
// Substring finder hit tracker
// Byte and match counters, forward pick, ring of recent starts, result select.
// -----------------------------------------------------------------------------
module sofc_hit_track import sofc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic fire,
	input  logic last,
	input  logic raw_hit,
	output logic shift_en,
	output res_t res
);

	localparam int WrapW = ((RING_AW > OCC_W) ? RING_AW : OCC_W) + 1;

	logic [CNT_W-1:0]   bc_q;
	logic [POS_W-1:0]   found_q;
	logic [POS_W-1:0]   fwd_q;
	logic [RING_AW-1:0] head_q;
	logic [POS_W-1:0]   ring_q [OCC_MAX];

	logic               room;
	logic               hit;
	logic [CNT_W-1:0]   bc_inc;
	logic [CNT_W-1:0]   bc_nx;
	logic [CNT_W-1:0]   start_w;
	logic [POS_W-1:0]   start;
	logic [POS_W-1:0]   found_nx;
	logic [POS_W-1:0]   fwd_nx;
	logic [RING_AW-1:0] head_inc;
	logic [RING_AW-1:0] head_nx;
	logic [POS_W-1:0]   stored;
	logic               sel_ok;
	logic [WrapW-1:0]   head_w;
	logic [WrapW-1:0]   occ_w;
	logic [WrapW-1:0]   idx_w;
	logic [RING_AW-1:0] idx;
	logic [POS_W-1:0]   ring_rd;
	logic [POS_W-1:0]   pos;

	always_comb begin
		room     = bc_q < CNT_W'(MAX_LENGTH);
		shift_en = fire && room;
		bc_inc   = bc_q + CNT_W'(1);
		bc_nx    = room ? bc_inc : CNT_W'(MAX_LENGTH + 1);
		hit      = shift_en && raw_hit && (bc_inc >= CNT_W'(cfg.len));
		start_w  = bc_inc - CNT_W'(cfg.len) + CNT_W'(1);
		start    = start_w[POS_W-1:0];

		found_nx = (hit && (found_q != {POS_W{1'b1}})) ? found_q + POS_W'(1) : found_q;
		fwd_nx   = (hit && (fwd_q == '0) && (cfg.occ != '0) && (found_nx == POS_W'(cfg.occ)))
			? start : fwd_q;

		head_inc = (head_q == RING_AW'(OCC_MAX - 1)) ? '0 : head_q + RING_AW'(1);
		head_nx  = hit ? head_inc : head_q;

		// Backward pick: occurrence n sits n entries behind the head.
		stored = (found_nx < POS_W'(OCC_MAX)) ? found_nx : POS_W'(OCC_MAX);
		sel_ok = (cfg.occ != '0) && (POS_W'(cfg.occ) <= stored);
		head_w = WrapW'(head_nx);
		occ_w  = WrapW'(cfg.occ);
		idx_w  = (head_w >= occ_w) ? head_w - occ_w : head_w + WrapW'(OCC_MAX) - occ_w;
		idx    = idx_w[RING_AW-1:0];
		// Bypass the entry being written this cycle.
		ring_rd = (hit && (idx == head_q)) ? start : ring_q[idx];

		case (cfg.mode)
			MODE_FORWARD:  pos = fwd_nx;
			MODE_BACKWARD: pos = sel_ok ? ring_rd : '0;
			default:       pos = '0;
		endcase

		res.match_position = pos;
		res.match_count    = found_nx;
		res.too_long       = bc_nx > CNT_W'(MAX_LENGTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q    <= '0;
			found_q <= '0;
			fwd_q   <= '0;
			head_q  <= '0;
		end else if (fire) begin
			if (last) begin
				bc_q    <= '0;
				found_q <= '0;
				fwd_q   <= '0;
				head_q  <= '0;
			end else begin
				bc_q    <= bc_nx;
				found_q <= found_nx;
				fwd_q   <= fwd_nx;
				head_q  <= head_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			ring_q[head_q] <= start;
		end
	end

endmodule

// ===== design/substring_occurrence_finder_core.sv =====
// -----------------------------------------------------------------------------
// Substring occurrence finder core
// Streams haystack bytes, one per cycle, and compares each new window with a
// needle of up to 16 bytes (exact or ASCII case-folded), counting overlapping
// matches. The item flagged last_byte yields one result: the 1-based start of
// the nth match from the front (forward mode), the nth match from the end out
// of the 16 most recent (backward mode), or only the count (count mode). A
// new byte is taken every cycle but for the stall below; a byte is held in the
// input register, and the result of a last byte is captured in the output
// register. The only stall is a last byte waiting on an output register whose
// result has not been taken. Bytes past 65535 are dropped and flag too_long.
// Config writes pass through the register file and the registered config image
// before they reach the datapath, and should be issued between strings.
// -----------------------------------------------------------------------------
module substring_occurrence_finder_core import sofc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sofc_in_if.sink              hay,
	sofc_out_if.source           result,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data
);

	cfg_t              cfg;

	// Input register.
	logic              s1_valid;
	logic [BYTE_W-1:0] s1_byte;
	logic              s1_last;
	logic              s1_go;

	// Output register.
	logic              out_valid_q;
	res_t              out_res_q;
	logic              out_free;

	logic              shift_en;
	logic              raw_hit;
	res_t              track_res;

	sofc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	sofc_window_match u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.hay_byte (s1_byte),
		.shift_en (shift_en),
		.clear    (s1_go && s1_last),
		.hit      (raw_hit)
	);

	sofc_hit_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.fire     (s1_go),
		.last     (s1_last),
		.raw_hit  (raw_hit),
		.shift_en (shift_en),
		.res      (track_res)
	);

	// A byte without last_byte always moves on; a last byte needs the output
	// register free or being drained this cycle.
	assign out_free  = !out_valid_q || result.ready;
	assign s1_go     = s1_valid && (!s1_last || out_free);
	assign hay.ready = !s1_valid || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (hay.valid && hay.ready) begin
			s1_valid <= 1'b1;
		end else if (s1_go) begin
			s1_valid <= 1'b0;
		end
	end

	// Payload of the input register: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (hay.valid && hay.ready) begin
			s1_byte <= hay.hay_byte;
			s1_last <= hay.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_last) begin
			out_res_q <= track_res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.match_position = out_res_q.match_position;
	assign result.match_count    = out_res_q.match_count;
	assign result.too_long       = out_res_q.too_long;

endmodule

// ===== design/sofc_checker.sv =====
// -----------------------------------------------------------------------------
// Substring finder port checker
// Port-level properties of the finder core, bound onto the top level.
// -----------------------------------------------------------------------------
`include "substring_occurrence_finder_core_assert.svh"

module sofc_checker import sofc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             hay_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [POS_W-1:0] res_position,
	input logic [POS_W-1:0] res_count,
	input logic             res_too_long
);

	// Hold a result that was not taken.
	`SOFC_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_position) && $stable(res_count) && $stable(res_too_long), "result changed while stalled")

	// Drop ready on the byte side only when a result is blocked.
	`SOFC_ASSERT_IMP(a_stall_cause, clk, arst_n, !hay_ready, res_valid && !res_ready, "input stalled without a blocked result")

	// A reported start implies at least one match was counted.
	`SOFC_ASSERT_IMP(a_pos_has_count, clk, arst_n, res_valid && (res_position != '0), res_count != '0, "position reported with zero matches")

endmodule

bind substring_occurrence_finder_core sofc_checker u_sofc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.hay_ready    (hay.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_position (result.match_position),
	.res_count    (result.match_count),
	.res_too_long (result.too_long)
);

// ===== verif/substring_occurrence_finder_core_tb.sv =====
// -----------------------------------------------------------------------------
// Substring occurrence finder testbench
// Streams haystack strings into the core under a series of needle, case, mode
// and occurrence settings and predicts each string's result in a scoreboard
// class. Results are compared field by field in arrival order while both
// channels idle and stall in random bursts.
// -----------------------------------------------------------------------------
module substring_occurrence_finder_core_tb import sofc_pkg::*;;

	// The mode field is two bits wide; its fourth code has no package name.
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Predicts the core from its registers and per-string state, one byte at a time,
	// and holds the results that are still on their way.
	class search_scoreboard;
		logic [2*CFG_W-1:0] needle;
		logic [LEN_W-1:0]   needle_len;
		logic               exact;
		logic [1:0]         mode;
		logic [OCC_W-1:0]   occ;

		logic [BYTE_W-1:0]  window[NEEDLE_MAX];
		logic [16:0]        byte_count;
		logic [POS_W-1:0]   found_count;
		logic [POS_W-1:0]   forward_hit;
		logic [POS_W-1:0]   recent_hits[OCC_MAX];
		logic [3:0]         recent_head;

		res_t expected_results[$];
		int   errors;

		function new();
			needle = '0;
			needle_len = '0;
			exact = 1'b1;
			mode = MODE_FORWARD;
			occ = 5'd1;
			errors = 0;
			foreach (recent_hits[i]) recent_hits[i] = '0;
			clear_string();
		endfunction

		function void clear_string();
			foreach (window[i]) window[i] = '0;
			byte_count = '0;
			found_count = '0;
			forward_hit = '0;
			recent_head = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_NEEDLE_LO:   needle[CFG_W-1:0] = d;
				REG_NEEDLE_HI:   needle[2*CFG_W-1:CFG_W] = d;
				REG_NEEDLE_LEN:  needle_len = d[LEN_W-1:0];
				REG_CASE_SENS:   exact = d[0];
				REG_SEARCH_MODE: mode = d[1:0];
				REG_OCCURRENCE:  occ = d[OCC_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [BYTE_W-1:0] lower(logic [BYTE_W-1:0] c);
			return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
		endfunction

		// Compare the newest needle_len window bytes with the needle, oldest first.
		function bit window_hit();
			logic [BYTE_W-1:0] n, h;
			if (needle_len == 0 || needle_len > NEEDLE_MAX) return 1'b0;
			if (byte_count < needle_len) return 1'b0;
			for (int i = 0; i < needle_len; i++) begin
				n = needle[8*i +: 8];
				h = window[needle_len - 1 - i];
				if (!exact) begin
					n = lower(n);
					h = lower(h);
				end
				if (n != h) return 1'b0;
			end
			return 1'b1;
		endfunction

		function void take_byte(logic [BYTE_W-1:0] b, logic tail);
			logic [POS_W-1:0] start;
			logic [POS_W-1:0] pos;
			int kept;
			res_t r;
			if (byte_count < MAX_LENGTH) begin
				for (int i = NEEDLE_MAX - 1; i > 0; i--) window[i] = window[i-1];
				window[0] = b;
				byte_count++;
				if (window_hit()) begin
					start = 16'(byte_count - needle_len + 1);
					if (found_count != 16'hFFFF) found_count++;
					if (forward_hit == 0 && occ != 0 && found_count == occ) forward_hit = start;
					recent_hits[recent_head] = start;
					recent_head++;
				end
			end else begin
				byte_count = 17'(MAX_LENGTH + 1);
			end
			if (!tail) return;
			pos = '0;
			if (mode == MODE_FORWARD) begin
				pos = forward_hit;
			end else if (mode == MODE_BACKWARD) begin
				kept = (found_count < OCC_MAX) ? found_count : OCC_MAX;
				if (occ != 0 && occ <= kept) pos = recent_hits[4'(recent_head - occ)];
			end
			r.match_position = pos;
			r.match_count = found_count;
			r.too_long = (byte_count > MAX_LENGTH);
			expected_results.push_back(r);
			clear_string();
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$error("result with no string pending: position %0d, count %0d",
					got.match_position, got.match_count);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			if (got.match_position !== want.match_position) begin
				$error("match_position: expected %0d, actual %0d",
					want.match_position, got.match_position);
				errors++;
			end
			if (got.match_count !== want.match_count) begin
				$error("match_count: expected %0d, actual %0d",
					want.match_count, got.match_count);
				errors++;
			end
			if (got.too_long !== want.too_long) begin
				$error("too_long: expected %0d, actual %0d", want.too_long, got.too_long);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0]     wr_data;

	sofc_in_if  hay_ch();
	sofc_out_if res_ch();

	search_scoreboard sb = new();

	logic [BYTE_W-1:0] hay_text[$];  // string to stream next
	int                bytes_sent = 0;
	bit                calm = 1'b0;  // set: no idling on either channel
	int                stall_left = 0;

	substring_occurrence_finder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.hay      (hay_ch),
		.result   (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run well beyond the slowest legal pass.
	initial begin
		#2000000;
		$display("substring_occurrence_finder_core_tb: done, errors");
		$finish;
	end

	// Result side: check every accepted result, then pick the next ready value.
	// Stalls come in random bursts.
	initial begin
		res_ch.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				sb.check_result('{match_position: res_ch.match_position,
					match_count: res_ch.match_count, too_long: res_ch.too_long});
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 14) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Mostly the letters a, b and their capitals so that short needles hit
	// often; the rest is any byte value.
	function automatic logic [BYTE_W-1:0] random_text_byte();
		logic [BYTE_W-1:0] c;
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		c = $urandom_range(0, 1) ? 8'h61 : 8'h62;
		if ($urandom_range(0, 1)) c ^= 8'h20;
		return c;
	endfunction

	// Stream hay_text as one string; the final byte carries the last mark.
	// Hold valid high across back-to-back items and drop it only for a gap.
	task automatic send_text();
		logic tail;
		for (int i = 0; i < hay_text.size(); i++) begin
			tail = (i == hay_text.size() - 1);
			if (!calm && $urandom_range(0, 7) == 0) begin
				hay_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			hay_ch.valid <= 1'b1;
			hay_ch.hay_byte <= hay_text[i];
			hay_ch.last_byte <= tail;
			do @(posedge clk); while (hay_ch.ready !== 1'b1);
			sb.take_byte(hay_text[i], tail);
			bytes_sent++;
		end
	endtask

	// Drop valid, wait for every pending result, then let the pipeline empty.
	task automatic wait_drained();
		hay_ch.valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	// Write all six registers while the core is idle.
	task automatic configure(logic [2*CFG_W-1:0] pat, logic [LEN_W-1:0] plen, logic exact,
			logic [1:0] smode, logic [OCC_W-1:0] nth);
		wait_drained();
		write_reg(REG_NEEDLE_LO, pat[CFG_W-1:0]);
		write_reg(REG_NEEDLE_HI, pat[2*CFG_W-1:CFG_W]);
		write_reg(REG_NEEDLE_LEN, CFG_W'(plen));
		write_reg(REG_CASE_SENS, CFG_W'(exact));
		write_reg(REG_SEARCH_MODE, CFG_W'(smode));
		write_reg(REG_OCCURRENCE, CFG_W'(nth));
		wr_en <= 1'b0;
	endtask

	initial begin
		logic [2*CFG_W-1:0] pat;
		int plen;
		int nth;
		int target;
		int base;
		logic [BYTE_W-1:0] c;

		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		hay_ch.valid <= 1'b0;
		hay_ch.hay_byte <= '0;
		hay_ch.last_byte <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: empty needle, nothing can match.
		hay_text = '{"a", "b"};
		send_text();

		// Overlapping hits of "aba" in "ababa", second one from the front.
		configure(128'h616261, 5'd3, 1'b1, MODE_FORWARD, 5'd2);
		hay_text = '{"a", "b", "a", "b", "a"};
		send_text();
		// Needle longer than the haystack.
		hay_text = '{"a", "b"};
		send_text();

		// Case folded, newest hit from the back.
		configure(128'h614261, 5'd3, 1'b0, MODE_BACKWARD, 5'd1);
		hay_text = '{"A", "b", "A", "b", "A"};
		send_text();
		// Occurrence beyond the ring.
		configure(128'h614261, 5'd3, 1'b0, MODE_BACKWARD, 5'd31);
		hay_text = '{"a", "B", "a"};
		send_text();

		// Over-long needle, spare mode code, occurrence zero, all-ones needle.
		configure({128{1'b1}}, 5'd31, 1'b1, MODE_SPARE, 5'd0);
		hay_text = '{8'hFF};
		send_text();
		// Zero byte needle against the byte extremes.
		configure(128'h0, 5'd1, 1'b1, MODE_COUNT, 5'd1);
		hay_text = '{8'h00, 8'hFF};
		send_text();

		// Random phases: fresh settings, then a few strings with embedded needles.
		base = bytes_sent;
		while (bytes_sent - base < 650) begin
			pat = '0;
			for (int j = 0; j < NEEDLE_MAX; j++) pat[8*j +: 8] = random_text_byte();
			case ($urandom_range(0, 15))
				0:       plen = 0;
				1:       plen = NEEDLE_MAX;
				2:       plen = $urandom_range(NEEDLE_MAX + 1, 31);
				3:       plen = $urandom_range(5, 15);
				default: plen = $urandom_range(1, 4);
			endcase
			case ($urandom_range(0, 11))
				0:       nth = 0;
				1:       nth = OCC_MAX;
				2:       nth = $urandom_range(OCC_MAX + 1, 31);
				3:       nth = $urandom_range(5, 15);
				default: nth = $urandom_range(1, 4);
			endcase
			configure(pat, 5'(plen), 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
				5'(nth));
			repeat ($urandom_range(1, 6)) begin
				// Drop idling for the tail of the run.
				calm = (bytes_sent - base > 560);
				target = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 90)
					: $urandom_range(1, 40);
				hay_text.delete();
				while (hay_text.size() < target) begin
					if (plen >= 1 && plen <= NEEDLE_MAX && $urandom_range(0, 3) == 0) begin
						for (int j = 0; j < plen; j++) begin
							c = pat[8*j +: 8];
							// Flip letter case now and then; only folding forgives it.
							if (((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A)
									&& $urandom_range(0, 5) == 0) c ^= 8'h20;
							hay_text.push_back(c);
						end
					end else begin
						hay_text.push_back(random_text_byte());
					end
				end
				send_text();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0) begin
			$display("substring_occurrence_finder_core_tb: done, clean");
		end else begin
			$display("substring_occurrence_finder_core_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== substring_occurrence_finder_core.f =====
+incdir+design
design/sofc_pkg.sv
design/sofc_in_if.sv
design/sofc_out_if.sv
design/sofc_cfg_regs.sv
design/sofc_window_match.sv
design/sofc_hit_track.sv
design/substring_occurrence_finder_core.sv
design/sofc_checker.sv
verif/substring_occurrence_finder_core_tb.sv
